// ----- sv/ihex_pkg.sv -----
// Shared types, codes and character helpers for the hex record loader.
package ihex_pkg;

  localparam int AddrWidth = 32;
  localparam logic [7:0] CharColon = 8'h3A;

  typedef enum logic [3:0] {
    PH_WAIT,
    PH_LEN,
    PH_ADDR,
    PH_TYPE,
    PH_DATA,
    PH_EXT,
    PH_START,
    PH_CHK,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_COLON  = 3'd1,
    ST_BAD_HEX   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_TYPE  = 3'd4,
    ST_CHECKSUM  = 3'd5
  } status_t;

  typedef enum logic [7:0] {
    RT_DATA      = 8'd0,
    RT_EOF       = 8'd1,
    RT_EXT_SEG   = 8'd2,
    RT_START_SEG = 8'd3,
    RT_EXT_LIN   = 8'd4,
    RT_START_LIN = 8'd5
  } rec_type_t;

  typedef enum logic [2:0] {
    TK_NONE,
    TK_ADDR,
    TK_DATA,
    TK_EXT_SEG,
    TK_EXT_LIN
  } tok_kind_t;

  // One classified character as handed from the parser to the executor.
  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] value;
    status_t     status;
    logic        done;
  } tok_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [3:0] field_nibbles(input phase_t ph);
    logic [3:0] n;
    unique case (ph)
      PH_ADDR, PH_EXT: n = 4'd4;
      PH_START:        n = 4'd8;
      default:         n = 4'd2;
    endcase
    return n;
  endfunction

endpackage

// ----- sv/ihex_front.sv -----
// Record parser: takes characters, tracks fields and checksum, emits tokens.
module ihex_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     char_in,
  input  logic           end_of_file,
  output ihex_pkg::tok_t tok
);
  import ihex_pkg::*;

  phase_t      phase, phase_next;
  status_t     stat, stat_next;
  logic [3:0]  nibble_count, nibble_count_next;
  logic [15:0] acc, acc_next;
  logic [7:0]  record_length, record_length_next;
  logic [7:0]  record_type, record_type_next;
  logic [7:0]  byte_counter, byte_counter_next;
  logic [7:0]  checksum, checksum_next;

  logic [4:0]  hex;
  logic        hex_ok;
  logic [3:0]  nib_inc;
  logic [15:0] acc_shift;
  logic [7:0]  sum_inc;
  logic [7:0]  bcnt_inc;
  logic        field_done;
  logic        running;

  assign hex        = hex_decode(char_in);
  assign hex_ok     = hex[4];
  assign nib_inc    = nibble_count + 4'd1;
  assign acc_shift  = {acc[11:0], hex[3:0]};
  // add a byte to the checksum on its second nibble
  assign sum_inc    = nibble_count[0] ? checksum + acc_shift[7:0] : checksum;
  assign bcnt_inc   = byte_counter + 8'd1;
  assign field_done = nib_inc >= field_nibbles(phase);
  assign running    = (phase != PH_DONE) && (phase != PH_ERR);

  // next phase and status
  always_comb begin
    phase_next = phase;
    stat_next  = stat;
    if (!running) begin
      phase_next = phase;
    end else if (end_of_file) begin
      if (phase == PH_WAIT) begin
        phase_next = PH_DONE;
      end else begin
        phase_next = PH_ERR;
        stat_next  = ST_BAD_HEX;
      end
    end else if (phase == PH_WAIT) begin
      if (char_in == CharColon) begin
        phase_next = PH_LEN;
      end else if (!is_space(char_in)) begin
        phase_next = PH_ERR;
        stat_next  = ST_NO_COLON;
      end
    end else if (!hex_ok) begin
      phase_next = PH_ERR;
      stat_next  = ST_BAD_HEX;
    end else if (field_done) begin
      unique case (phase)
        PH_LEN:  phase_next = PH_ADDR;
        PH_ADDR: phase_next = PH_TYPE;
        PH_TYPE: begin
          priority case (acc_shift[7:0])
            RT_DATA: phase_next = (record_length == 8'd0) ? PH_CHK : PH_DATA;
            RT_EOF:  phase_next = PH_DONE;
            RT_EXT_SEG, RT_EXT_LIN: begin
              if (record_length != 8'd2) begin
                phase_next = PH_ERR;
                stat_next  = ST_BAD_LEN;
              end else begin
                phase_next = PH_EXT;
              end
            end
            RT_START_SEG, RT_START_LIN: begin
              if (record_length != 8'd4) begin
                phase_next = PH_ERR;
                stat_next  = ST_BAD_LEN;
              end else begin
                phase_next = PH_START;
              end
            end
            default: begin
              phase_next = PH_ERR;
              stat_next  = ST_BAD_TYPE;
            end
          endcase
        end
        PH_DATA:  phase_next = (bcnt_inc == record_length) ? PH_CHK : PH_DATA;
        PH_EXT:   phase_next = PH_CHK;
        PH_START: phase_next = PH_CHK;
        PH_CHK: begin
          if (sum_inc != 8'd0) begin
            phase_next = PH_ERR;
            stat_next  = ST_CHECKSUM;
          end else begin
            phase_next = PH_WAIT;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // field datapath and token
  always_comb begin
    nibble_count_next  = nibble_count;
    acc_next           = acc;
    checksum_next      = checksum;
    record_length_next = record_length;
    record_type_next   = record_type;
    byte_counter_next  = byte_counter;
    tok.kind           = TK_NONE;
    tok.value          = acc_shift;
    tok.status         = stat_next;
    tok.done           = (phase_next == PH_DONE);
    if (running && !end_of_file) begin
      if (phase == PH_WAIT) begin
        if (char_in == CharColon) begin
          nibble_count_next = 4'd0;
          acc_next          = 16'd0;
          checksum_next     = 8'd0;
        end
      end else if (hex_ok) begin
        acc_next          = acc_shift;
        nibble_count_next = nib_inc;
        checksum_next     = sum_inc;
        if (field_done) begin
          nibble_count_next = 4'd0;
          acc_next          = 16'd0;
          unique case (phase)
            PH_LEN:  record_length_next = acc_shift[7:0];
            PH_ADDR: tok.kind = TK_ADDR;
            PH_TYPE: begin
              record_type_next  = acc_shift[7:0];
              byte_counter_next = 8'd0;
            end
            PH_DATA: begin
              tok.kind          = TK_DATA;
              byte_counter_next = bcnt_inc;
            end
            PH_EXT:  tok.kind = (record_type == RT_EXT_SEG) ? TK_EXT_SEG : TK_EXT_LIN;
            default: tok.kind = TK_NONE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      stat          <= ST_OK;
      nibble_count  <= 4'd0;
      acc           <= 16'd0;
      checksum      <= 8'd0;
      record_length <= 8'd0;
      record_type   <= 8'd0;
      byte_counter  <= 8'd0;
    end else if (accept) begin
      phase         <= phase_next;
      stat          <= stat_next;
      nibble_count  <= nibble_count_next;
      acc           <= acc_next;
      checksum      <= checksum_next;
      record_length <= record_length_next;
      record_type   <= record_type_next;
      byte_counter  <= byte_counter_next;
    end
  end

endmodule

// ----- sv/ihex_queue.sv -----
// Two-entry token queue between parser and executor.
module ihex_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ihex_pkg::tok_t push_tok,
  input  logic           pop,
  output ihex_pkg::tok_t head,
  output logic           full,
  output logic           empty
);
  import ihex_pkg::*;

  tok_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/ihex_back.sv -----
// Executor: forms addresses, issues writes, tracks extremes, holds the result word.
module ihex_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_valid,
  input  ihex_pkg::tok_t tok,
  output logic           pop,
  input  logic [31:0]    load_offset,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           write_valid,
  output logic [31:0]    write_addr,
  output logic [7:0]     write_data,
  output logic [2:0]     status,
  output logic           done_res,
  output logic [31:0]    lowest_addr,
  output logic [31:0]    highest_addr,
  output logic [31:0]    image_size,
  output logic [31:0]    ignored_bytes
);
  import ihex_pkg::*;

  logic [AddrWidth-1:0] cur, min_seen, max_seen, ignored_count;
  logic [19:0]          segment_base;
  logic [15:0]          linear_base;
  logic                 any_data;
  logic [AddrWidth:0]   diff;
  logic                 below;
  logic [AddrWidth-1:0] addr_full;
  logic                 is_data;
  logic                 hit;

  assign pop       = tok_valid && (!out_valid || out_ready);
  assign diff      = {1'b0, cur} - {1'b0, load_offset};
  assign below     = diff[AddrWidth];
  assign addr_full = {linear_base, tok.value} + {12'd0, segment_base};
  assign is_data   = (tok.kind == TK_DATA);
  assign hit       = is_data && !below;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      cur           <= '0;
      segment_base  <= 20'd0;
      linear_base   <= 16'd0;
      min_seen      <= '1;
      max_seen      <= '0;
      ignored_count <= '0;
      any_data      <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (tok.kind)
          TK_ADDR: cur <= addr_full;
          TK_EXT_SEG: begin
            segment_base <= {tok.value, 4'd0};
            linear_base  <= 16'd0;
          end
          TK_EXT_LIN: begin
            linear_base  <= tok.value;
            segment_base <= 20'd0;
          end
          TK_DATA: begin
            if (below && (ignored_count != '1)) begin
              ignored_count <= ignored_count + 32'd1;
            end
            if (cur > max_seen) begin
              max_seen <= cur;
            end
            if (cur < min_seen) begin
              min_seen <= cur;
            end
            any_data <= 1'b1;
            cur      <= cur + 32'd1;
          end
          default: cur <= cur;
        endcase
      end
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (pop) begin
      write_valid <= hit;
      write_addr  <= hit ? diff[AddrWidth-1:0] : '0;
      write_data  <= hit ? tok.value[7:0] : 8'd0;
      status      <= tok.status;
      done_res    <= tok.done;
    end
  end

  assign lowest_addr   = min_seen;
  assign highest_addr  = max_seen;
  assign ignored_bytes = ignored_count;
  assign image_size    = any_data ? (max_seen - min_seen + 32'd1) : '0;

endmodule

// ----- sv/intel_hex_record_loader.sv -----
// Top level of the hex record loader: parser, token queue and executor.
//
//   channel   signals                                  direction
//   input     in_valid/in_ready, char_in, end_of_file  in
//   result    out_valid/out_ready, write_*, status,    out
//             done_res, *_addr, image_size, ignored_bytes
//   config    cfg_we, cfg_data (load_offset)           in
//
// One character is accepted per cycle while in_ready is high; its token is
// held in the queue and loaded into the result word once no word waits ahead
// of it and the result side does not stall.
// Reset clears all parse and tracking state; load_offset resets to zero.
// A stalled result side fills the queue, then in_ready drops until a word
// leaves it; the cycle in which that word leaves still refuses input.
module intel_hex_record_loader (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        end_of_file,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_valid,
  output logic [31:0] write_addr,
  output logic [7:0]  write_data,
  output logic [2:0]  status,
  output logic        done_res,
  output logic [31:0] lowest_addr,
  output logic [31:0] highest_addr,
  output logic [31:0] image_size,
  output logic [31:0] ignored_bytes
);
  import ihex_pkg::*;

  logic [31:0] load_offset;
  logic        accept;
  tok_t        front_tok;
  tok_t        head_tok;
  logic        q_full, q_empty;
  logic        pop;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_offset <= 32'd0;
    end else if (cfg_we) begin
      load_offset <= cfg_data;
    end
  end

  ihex_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_in     (char_in),
    .end_of_file (end_of_file),
    .tok         (front_tok)
  );

  ihex_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_tok (front_tok),
    .pop      (pop),
    .head     (head_tok),
    .full     (q_full),
    .empty    (q_empty)
  );

  ihex_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tok_valid     (!q_empty),
    .tok           (head_tok),
    .pop           (pop),
    .load_offset   (load_offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_valid   (write_valid),
    .write_addr    (write_addr),
    .write_data    (write_data),
    .status        (status),
    .done_res      (done_res),
    .lowest_addr   (lowest_addr),
    .highest_addr  (highest_addr),
    .image_size    (image_size),
    .ignored_bytes (ignored_bytes)
  );

  // a write word is only ever issued while parsing runs cleanly
  a_write_ok : assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_valid) |-> (status == ST_OK && !done_res))
    else $error("write issued after stop");

  // finished and failed never show together
  a_done_err : assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (status == ST_OK))
    else $error("done with error status");

  // the queue only pops tokens it holds
  a_pop_held : assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
